### src/tvs_pkg.sv
`timescale 1ns / 1ps

package tvs_pkg;

    localparam int CORDIC_STEPS_DEF  = 24;
    localparam int POS_FRAC_BITS_DEF = 16;

    localparam int KIND_W   = 3;
    localparam int AMOUNT_W = 24;
    localparam int ORIGIN_W = 15;
    localparam int PIXEL_W  = 16;
    localparam int ANGLE_W  = 32;
    localparam int TRIG_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] CMD_RESET    = 3'd0;
    localparam logic [KIND_W-1:0] CMD_TURN     = 3'd1;
    localparam logic [KIND_W-1:0] CMD_MOVE     = 3'd2;
    localparam logic [KIND_W-1:0] CMD_PEN_UP   = 3'd3;
    localparam logic [KIND_W-1:0] CMD_PEN_DOWN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'd1;

    localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 15'd320;
    localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 15'd240;

    // turn: q = (|a| * 2^24 + 180) / 360 = (|a| * 2^21 + 22) / 45
    // x / 45 = (x * TURN_RECIP) >> TURN_RECIP_SH, exact for x below 2^28
    localparam int TURN_SHIFT = 21;
    localparam logic [TURN_SHIFT-1:0] TURN_BIAS = 21'd22;
    localparam int TURN_REM_W = 6;
    localparam logic [TURN_REM_W-1:0] TURN_DIVISOR = 6'd45;
    localparam int TURN_NUM_W = TURN_REM_W + TURN_SHIFT;
    localparam int TURN_RECIP_W = 28;
    localparam logic [TURN_RECIP_W-1:0] TURN_RECIP = 28'd190887436;
    localparam int TURN_RECIP_SH = 33;

    // cordic datapath
    localparam int CX_W = 34;
    localparam int CZ_W = 33;
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [AMOUNT_W-1:0] amount;
    } in_t;

    typedef struct packed {
        logic                      draw;
        logic                      clear;
        logic signed [PIXEL_W-1:0] start_x;
        logic signed [PIXEL_W-1:0] start_y;
        logic signed [PIXEL_W-1:0] end_x;
        logic signed [PIXEL_W-1:0] end_y;
        logic                      saturated;
    } out_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### src/tvs_turn_div.sv
`timescale 1ns / 1ps

module tvs_turn_div
    import tvs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [AMOUNT_W-1:0] mag,
    output logic                done,
    output logic [ANGLE_W-1:0]  quot
);

    localparam int PROD_W = TURN_NUM_W + TURN_RECIP_W;
    localparam int PQ_W   = PROD_W - TURN_RECIP_SH;
    localparam int QM_W   = AMOUNT_W - 5;
    localparam int HI_W   = ANGLE_W - TURN_SHIFT;

    typedef enum logic [1:0] {
        PH_IDLE, PH_DIV_HI, PH_REM, PH_DIV_LO
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  done_reg, done_next;
    logic [TURN_NUM_W-1:0] num_reg, num_next;
    logic [QM_W-1:0]       qm_reg, qm_next;
    logic [ANGLE_W-1:0]    quot_reg, quot_next;
    logic [PROD_W-1:0]     prod;
    logic [PQ_W-1:0]       pq;
    logic [TURN_NUM_W-1:0] back;
    logic [TURN_NUM_W-1:0] remv;

    // reciprocal multiply by 1/45: high quotient bits from |a| / 45,
    // low bits from (remainder * 2^21 + 22) / 45
    always_comb begin
        prod       = PROD_W'(num_reg) * PROD_W'(TURN_RECIP);
        pq         = prod[PROD_W-1:TURN_RECIP_SH];
        back       = TURN_NUM_W'(qm_reg) * TURN_NUM_W'(TURN_DIVISOR);
        remv       = num_reg - back;
        phase_next = phase_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        qm_next    = qm_reg;
        quot_next  = quot_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    num_next   = TURN_NUM_W'(mag);
                    phase_next = PH_DIV_HI;
                end
            end
            PH_DIV_HI: begin
                qm_next    = pq[QM_W-1:0];
                phase_next = PH_REM;
            end
            PH_REM: begin
                num_next   = {remv[TURN_REM_W-1:0], TURN_BIAS};
                phase_next = PH_DIV_LO;
            end
            PH_DIV_LO: begin
                quot_next  = {qm_reg[HI_W-1:0], pq[TURN_SHIFT-1:0]};
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        num_reg  <= num_next;
        qm_reg   <= qm_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### src/tvs_cordic.sv
`timescale 1ns / 1ps

module tvs_cordic
    import tvs_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [ANGLE_W-1:0]       angle,
    output logic                     done,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       i_reg, i_next;
    logic [1:0]             quad_reg, quad_next;
    logic signed [CX_W-1:0] x_reg, x_next;
    logic signed [CX_W-1:0] y_reg, y_next;
    logic signed [CZ_W-1:0] z_reg, z_next;
    logic signed [CX_W-1:0] xs, ys;
    logic signed [CZ_W-1:0] at;
    logic                   dir;

    always_comb begin
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        at        = $signed({1'b0, atan_lut(5'(i_reg))});
        dir       = ~z_reg[CZ_W-1];
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        quad_next = quad_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            i_next    = '0;
            quad_next = angle[ANGLE_W-1 -: 2];
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = $signed({3'b000, angle[ANGLE_W-3:0]});
        end else if (busy_reg) begin
            x_next = dir ? x_reg - ys : x_reg + ys;
            y_next = dir ? y_reg + xs : y_reg - xs;
            z_next = dir ? z_reg - at : z_reg + at;
            i_next = i_reg + 1'b1;
            if (i_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        i_reg    <= i_next;
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // quadrant fold back
    always_comb begin
        unique case (quad_reg)
            2'd0: begin
                cos_out = TRIG_W'(x_reg);
                sin_out = TRIG_W'(y_reg);
            end
            2'd1: begin
                cos_out = TRIG_W'(-y_reg);
                sin_out = TRIG_W'(x_reg);
            end
            2'd2: begin
                cos_out = TRIG_W'(-x_reg);
                sin_out = TRIG_W'(-y_reg);
            end
            default: begin
                cos_out = TRIG_W'(y_reg);
                sin_out = TRIG_W'(-x_reg);
            end
        endcase
    end

    assign done = done_reg;

endmodule

### src/turtle_vector_stepper.sv
`timescale 1ns / 1ps
// channel   | ports                          | payload
// ----------+--------------------------------+-----------------------------
// command   | s_valid, s_ready, s_data       | in_t: kind, amount
// segment   | m_valid, m_ready, m_data       | out_t: draw .. saturated
// config    | cfg_wr_en, cfg_index, cfg_data | origin_x, origin_y
//
// one command at a time; s_ready is high only while the sequencer is idle
// steps from one accepted command to the next:
// move: iterative cordic, then one shared multiplier and adder for x and y;
// turn: reciprocal multiply by 1/45 in three steps; reset, pen and unused
// commands go straight to the result stage (ST_FIN)
// a finished segment sits in the output register; the next command is taken
// while it waits, and the sequencer holds only when a second result is ready
// aresetn is synchronous: origin 320/240, turtle at origin, heading 0, pen down

module turtle_vector_stepper
    import tvs_pkg::*;
#(
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ORIGIN_W-1:0]  cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    localparam int POS_W   = PIXEL_W + POS_FRAC_BITS;
    localparam int SUM_W   = POS_W + 2;
    localparam int PROD_W  = AMOUNT_W + TRIG_W;
    localparam int SH      = 38 - POS_FRAC_BITS;
    localparam logic signed [PROD_W:0] HALF_MUL = (PROD_W + 1)'(1) << (SH - 1);
    localparam logic signed [POS_W:0]  HALF_PX  = (POS_W + 1)'(1) << (POS_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] POS_MIN =
        SUM_W'(-(longint'(32768) <<< POS_FRAC_BITS));
    localparam logic signed [SUM_W-1:0] POS_MAX =
        SUM_W'(longint'(32767) <<< POS_FRAC_BITS);
    localparam logic signed [PIXEL_W:0] PX_MAX = 17'sd32767;
    localparam logic signed [PIXEL_W:0] PX_MIN = -17'sd32768;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TURN, ST_ROT, ST_MUL_X, ST_ADD_X, ST_ADD_Y, ST_FIN
    } state_t;

    state_t                      state_reg, state_next;
    logic [ORIGIN_W-1:0]         origin_x_reg, origin_x_next;
    logic [ORIGIN_W-1:0]         origin_y_reg, origin_y_next;
    logic signed [POS_W-1:0]     pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]     pos_y_reg, pos_y_next;
    logic [ANGLE_W-1:0]          heading_reg, heading_next;
    logic                        pen_reg, pen_next;
    logic [KIND_W-1:0]           kind_reg, kind_next;
    logic signed [AMOUNT_W-1:0]  amount_reg, amount_next;
    logic signed [PIXEL_W-1:0]   start_x_reg, start_x_next;
    logic signed [PIXEL_W-1:0]   start_y_reg, start_y_next;
    logic                        sat_reg, sat_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        m_valid_reg, m_valid_next;
    out_t                        out_reg, out_next;

    logic                        accept;
    logic                        div_start, div_done;
    logic [ANGLE_W-1:0]          div_quot;
    logic [AMOUNT_W-1:0]         amount_mag;
    logic                        rot_start, rot_done;
    logic signed [TRIG_W-1:0]    rot_cos, rot_sin;
    logic signed [TRIG_W-1:0]    mul_b;
    logic signed [PROD_W:0]      rnd_sum;
    logic signed [PROD_W:0]      rnd_shift;
    logic signed [SUM_W-1:0]     delta;
    logic signed [POS_W-1:0]     add_a;
    logic signed [SUM_W-1:0]     pos_sum;
    logic                        pos_lo, pos_hi;
    logic signed [POS_W-1:0]     pos_clamped;
    logic signed [PIXEL_W-1:0]   px_x, px_y;

    function automatic logic signed [PIXEL_W-1:0] round_px(input logic signed [POS_W-1:0] p);
        logic signed [POS_W:0]   t;
        logic signed [POS_W:0]   ts;
        logic signed [PIXEL_W:0] r;
        logic signed [PIXEL_W-1:0] v;
        t  = $signed({p[POS_W-1], p}) + HALF_PX;
        ts = t >>> POS_FRAC_BITS;
        r  = ts[PIXEL_W:0];
        if (r > PX_MAX) begin
            v = PX_MAX[PIXEL_W-1:0];
        end else if (r < PX_MIN) begin
            v = PX_MIN[PIXEL_W-1:0];
        end else begin
            v = r[PIXEL_W-1:0];
        end
        return v;
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign div_start  = accept && (s_data.kind == CMD_TURN);
    assign rot_start  = accept && (s_data.kind == CMD_MOVE);
    assign amount_mag = s_data.amount[AMOUNT_W-1] ? AMOUNT_W'(-s_data.amount)
                                                  : AMOUNT_W'(s_data.amount);

    tvs_turn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (amount_mag),
        .done    (div_done),
        .quot    (div_quot)
    );

    tvs_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rot_start),
        .angle   (heading_reg),
        .done    (rot_done),
        .cos_out (rot_cos),
        .sin_out (rot_sin)
    );

    // shared multiplier, rounding and saturating position adder
    always_comb begin
        mul_b       = (state_reg == ST_MUL_X) ? rot_cos : rot_sin;
        prod_next   = PROD_W'(amount_reg) * PROD_W'(mul_b);
        rnd_sum     = $signed({prod_reg[PROD_W-1], prod_reg}) + HALF_MUL;
        rnd_shift   = rnd_sum >>> SH;
        delta       = rnd_shift[SUM_W-1:0];
        add_a       = (state_reg == ST_ADD_X) ? pos_x_reg : pos_y_reg;
        pos_sum     = $signed({{2{add_a[POS_W-1]}}, add_a}) + delta;
        pos_lo      = pos_sum < POS_MIN;
        pos_hi      = pos_sum > POS_MAX;
        pos_clamped = pos_lo ? POS_MIN[POS_W-1:0] :
                      pos_hi ? POS_MAX[POS_W-1:0] : pos_sum[POS_W-1:0];
        px_x        = round_px(pos_x_reg);
        px_y        = round_px(pos_y_reg);
    end

    always_comb begin
        state_next    = state_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        heading_next  = heading_reg;
        pen_next      = pen_reg;
        kind_next     = kind_reg;
        amount_next   = amount_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        sat_next      = sat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_next = cfg_data;
                CFG_ORIGIN_Y: origin_y_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next    = s_data.kind;
                    amount_next  = s_data.amount;
                    start_x_next = px_x;
                    start_y_next = px_y;
                    sat_next     = 1'b0;
                    case (s_data.kind)
                        CMD_RESET: begin
                            pos_x_next   = $signed({1'b0, origin_x_reg,
                                                    {POS_FRAC_BITS{1'b0}}});
                            pos_y_next   = $signed({1'b0, origin_y_reg,
                                                    {POS_FRAC_BITS{1'b0}}});
                            heading_next = '0;
                            pen_next     = 1'b1;
                            state_next   = ST_FIN;
                        end
                        CMD_TURN:     state_next = ST_TURN;
                        CMD_MOVE:     state_next = ST_ROT;
                        CMD_PEN_UP: begin
                            pen_next   = 1'b0;
                            state_next = ST_FIN;
                        end
                        CMD_PEN_DOWN: begin
                            pen_next   = 1'b1;
                            state_next = ST_FIN;
                        end
                        default:      state_next = ST_FIN;
                    endcase
                end
            end
            ST_TURN: begin
                if (div_done) begin
                    heading_next = amount_reg[AMOUNT_W-1] ? heading_reg - div_quot
                                                          : heading_reg + div_quot;
                    state_next   = ST_FIN;
                end
            end
            ST_ROT: begin
                if (rot_done) begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                state_next = ST_ADD_X;
            end
            ST_ADD_X: begin
                pos_x_next = pos_clamped;
                sat_next   = sat_reg | pos_lo | pos_hi;
                state_next = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                pos_y_next = pos_clamped;
                sat_next   = sat_reg | pos_lo | pos_hi;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.draw      = (kind_reg == CMD_MOVE) && pen_reg;
                    out_next.clear     = (kind_reg == CMD_RESET);
                    out_next.start_x   = (kind_reg == CMD_MOVE) ? start_x_reg : px_x;
                    out_next.start_y   = (kind_reg == CMD_MOVE) ? start_y_reg : px_y;
                    out_next.end_x     = px_x;
                    out_next.end_y     = px_y;
                    out_next.saturated = sat_reg;
                    m_valid_next       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            origin_x_reg <= ORIGIN_X_RST;
            origin_y_reg <= ORIGIN_Y_RST;
            pos_x_reg    <= $signed({1'b0, ORIGIN_X_RST, {POS_FRAC_BITS{1'b0}}});
            pos_y_reg    <= $signed({1'b0, ORIGIN_Y_RST, {POS_FRAC_BITS{1'b0}}});
            heading_reg  <= '0;
            pen_reg      <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            heading_reg  <= heading_next;
            pen_reg      <= pen_next;
            m_valid_reg  <= m_valid_next;
        end
        kind_reg    <= kind_next;
        amount_reg  <= amount_next;
        start_x_reg <= start_x_next;
        start_y_reg <= start_y_next;
        sat_reg     <= sat_next;
        prod_reg    <= prod_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
